FILE: design/smm_pkg.sv
// Shared types and constants for the set membership mask block.
// Used by the cell, the top level and the port checker; no dependencies.
`default_nettype none

package smm_pkg;

  // The comparator chain has a fixed number of cells; entry k of the test set
  // lives in cell (k mod NUM_CELLS) at row (k / NUM_CELLS).
  localparam int NUM_CELLS = 8;
  localparam int CELL_W    = 3;

  localparam int          OUT_W     = 32;
  localparam logic [31:0] MASK_ALL  = 32'hFFFF_FFFF;
  localparam logic [31:0] MASK_NONE = 32'h0000_0000;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_QUERY = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SWEEP = 2'd1,
    ST_DRAIN = 2'd2
  } state_t;

  // Control part of a row token moving down the cell chain.
  typedef struct packed {
    logic valid;
    logic last;
    logic hit;
  } smm_tok_t;

endpackage

`default_nettype wire

FILE: design/smm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module smm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: design/smm_cell.sv
// One cell of the comparator chain: a bank of the test set and one comparator.
// Depends on smm_pkg and smm_ram.
`default_nettype none

module smm_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int ROWS       = 128,
  parameter int ROW_W      = 7,
  parameter int CNT_W      = 11,
  parameter int CELL_IDX   = 0
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [CNT_W-1:0]             count,
  input  wire logic                         ld_en,
  input  wire logic [smm_pkg::CELL_W-1:0]   ld_cell,
  input  wire logic [ROW_W-1:0]             ld_row,
  input  wire logic [DATA_WIDTH-1:0]        ld_data,
  input  wire smm_pkg::smm_tok_t            tok_in,
  input  wire logic [ROW_W-1:0]             row_in,
  input  wire logic [DATA_WIDTH-1:0]        key_in,
  output smm_pkg::smm_tok_t                 tok_out,
  output logic      [ROW_W-1:0]             row_out,
  output logic      [DATA_WIDTH-1:0]        key_out
);

  localparam int CELL_W = smm_pkg::CELL_W;
  localparam int CMP_W  = (ROW_W + CELL_W > CNT_W) ? ROW_W + CELL_W : CNT_W;

  smm_pkg::smm_tok_t       tok_a_r;
  logic [ROW_W-1:0]        row_a_r;
  logic [DATA_WIDTH-1:0]   key_a_r;
  logic [DATA_WIDTH-1:0]   rd_data;
  logic [CMP_W-1:0]        ent_idx;
  logic                    ent_valid;
  logic                    wr_en;

  assign wr_en = ld_en && (ld_cell == CELL_W'(CELL_IDX));

  // The bank is read with the incoming row, so the data lines up with the
  // token once it has been registered here.
  smm_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (ROWS),
    .AW    (ROW_W)
  ) u_bank (
    .clk   (clk),
    .we    (wr_en),
    .waddr (ld_row),
    .wdata (ld_data),
    .raddr (row_in),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_a_r <= '0;
    end else begin
      tok_a_r <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    row_a_r <= row_in;
    key_a_r <= key_in;
  end

  // Only entries below the fill count take part; the rest of the last row
  // holds stale or never-written data.
  assign ent_idx   = CMP_W'({row_a_r, CELL_W'(CELL_IDX)});
  assign ent_valid = ent_idx < CMP_W'(count);

  always_comb begin
    tok_out       = tok_a_r;
    tok_out.hit   = tok_a_r.hit || (tok_a_r.valid && ent_valid && (rd_data == key_a_r));
  end

  assign row_out = row_a_r;
  assign key_out = key_a_r;

endmodule

`default_nettype wire

FILE: design/set_membership_mask.sv
// Set membership mask engine: the top level with the sequencer and the cell chain.
// Depends on smm_pkg, smm_cell and smm_ram.
//
// A load or clear transaction completes with busy kept low. A query against an empty
// set also keeps busy low, and its result appears in the next cycle. A query against a
// set of N entries holds busy high while it runs: the sequencer feeds one row of the
// eight-bank store into the cell chain per cycle, and each row token then passes through
// eight cells, one comparator and one bank read per cell. The result shows on the
// out_ ports for exactly one cycle with out_valid high, in the same cycle that busy
// falls; the receiver cannot hold it off. The test store needs no clearing after reset,
// since only entries below the fill count are ever compared.
`default_nettype none

module set_membership_mask #(
  parameter int DATA_WIDTH = 32,
  parameter int SET_DEPTH  = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_action,
  input  wire logic [31:0] in_value,
  input  wire logic        in_last_element,
  output logic             out_valid,
  output logic      [31:0] out_mask_word,
  output logic             out_found,
  output logic             out_set_overflowed,
  output logic             out_end_of_tensor,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata
);

  localparam int NC     = smm_pkg::NUM_CELLS;
  localparam int CELL_W = smm_pkg::CELL_W;
  localparam int CNT_W  = $clog2(SET_DEPTH + 1);
  localparam int ROWS   = (SET_DEPTH + NC - 1) / NC;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IDX_W  = (CNT_W > CELL_W) ? CNT_W : CELL_W + 1;

  smm_pkg::state_t         state_r, state_nxt;
  logic [CNT_W-1:0]        count_r;
  logic                    ovf_r;
  logic                    invert_r;
  logic [DATA_WIDTH-1:0]   key_r;
  logic                    last_elem_r;
  logic [ROW_W-1:0]        row_r;
  logic [ROW_W-1:0]        last_row_r;
  logic                    hit_acc_r;
  logic                    out_valid_r;
  logic                    out_found_r;
  logic                    out_ovf_r;
  logic                    out_eot_r;

  logic                    accept;
  logic                    is_load, is_query;
  logic                    full, empty;
  logic [IDX_W-1:0]        count_ext;
  logic [IDX_W-1:0]        count_m1;
  logic [DATA_WIDTH-1:0]   key_in;
  logic                    ld_en;
  logic [CELL_W-1:0]       ld_cell;
  logic [ROW_W-1:0]        ld_row;
  logic                    exit_hit;
  smm_pkg::smm_tok_t       tok_head;
  smm_pkg::smm_tok_t       tok_exit;

  smm_pkg::smm_tok_t       tok_c [NC+1];
  logic [ROW_W-1:0]        row_c [NC+1];
  logic [DATA_WIDTH-1:0]   key_c [NC+1];

  assign accept   = start && !busy;
  assign is_load  = (in_action == smm_pkg::ACT_LOAD);
  assign is_query = (in_action == smm_pkg::ACT_QUERY);

  assign full      = (count_r == CNT_W'(SET_DEPTH));
  assign empty     = (count_r == '0);
  assign count_ext = IDX_W'(count_r);
  assign count_m1  = count_ext - IDX_W'(1);
  assign key_in    = DATA_WIDTH'(in_value);

  // New entries go to the bank and row picked by the current fill count.
  assign ld_en   = accept && is_load && !full;
  assign ld_cell = count_ext[CELL_W-1:0];
  assign ld_row  = ROW_W'(count_ext >> CELL_W);

  always_comb begin
    state_nxt = state_r;
    tok_head  = '0;
    case (state_r)
      smm_pkg::ST_IDLE: begin
        if (accept && is_query && !empty) begin
          state_nxt = smm_pkg::ST_SWEEP;
        end
      end
      smm_pkg::ST_SWEEP: begin
        tok_head.valid = 1'b1;
        tok_head.last  = (row_r == last_row_r);
        if (row_r == last_row_r) begin
          state_nxt = smm_pkg::ST_DRAIN;
        end
      end
      smm_pkg::ST_DRAIN: begin
        if (tok_exit.valid && tok_exit.last) begin
          state_nxt = smm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = smm_pkg::ST_IDLE;
      end
    endcase
  end

  assign tok_c[0] = tok_head;
  assign row_c[0] = row_r;
  assign key_c[0] = key_r;
  assign tok_exit = tok_c[NC];

  for (genvar i = 0; i < NC; i++) begin : g_cell
    smm_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .ROWS       (ROWS),
      .ROW_W      (ROW_W),
      .CNT_W      (CNT_W),
      .CELL_IDX   (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .count   (count_r),
      .ld_en   (ld_en),
      .ld_cell (ld_cell),
      .ld_row  (ld_row),
      .ld_data (key_in),
      .tok_in  (tok_c[i]),
      .row_in  (row_c[i]),
      .key_in  (key_c[i]),
      .tok_out (tok_c[i+1]),
      .row_out (row_c[i+1]),
      .key_out (key_c[i+1])
    );
  end

  assign exit_hit = hit_acc_r || tok_exit.hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= smm_pkg::ST_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      invert_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        invert_r <= cfg_wdata;
      end
      if (accept) begin
        case (in_action)
          smm_pkg::ACT_LOAD: begin
            if (full) begin
              ovf_r <= 1'b1;
            end else begin
              count_r <= count_r + CNT_W'(1);
            end
          end
          smm_pkg::ACT_CLEAR: begin
            count_r <= '0;
            ovf_r   <= 1'b0;
          end
          smm_pkg::ACT_QUERY: begin
            if (empty) begin
              out_valid_r <= 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      if (tok_exit.valid && tok_exit.last) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_query) begin
      key_r       <= key_in;
      last_elem_r <= in_last_element;
      row_r       <= '0;
      last_row_r  <= ROW_W'(count_m1 >> CELL_W);
      hit_acc_r   <= 1'b0;
      // An empty set never matches, so the answer is just the invert setting.
      out_found_r <= invert_r;
      out_ovf_r   <= ovf_r;
      out_eot_r   <= in_last_element;
    end else begin
      if (state_r == smm_pkg::ST_SWEEP) begin
        row_r <= row_r + ROW_W'(1);
      end
      if (tok_exit.valid) begin
        hit_acc_r <= exit_hit;
        if (tok_exit.last) begin
          out_found_r <= exit_hit ^ invert_r;
          out_ovf_r   <= ovf_r;
          out_eot_r   <= last_elem_r;
        end
      end
    end
  end

  assign busy               = (state_r != smm_pkg::ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_found          = out_found_r;
  assign out_mask_word      = out_found_r ? smm_pkg::MASK_ALL : smm_pkg::MASK_NONE;
  assign out_set_overflowed = out_ovf_r;
  assign out_end_of_tensor  = out_eot_r;

endmodule

`default_nettype wire

FILE: design/smm_checker.sv
// Port-level checker for set_membership_mask and the bind that attaches it.
// Depends on smm_pkg and set_membership_mask.
`default_nettype none

module smm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [1:0]  in_action,
  input wire logic        out_valid,
  input wire logic [31:0] out_mask_word,
  input wire logic        out_found
);

  logic query_acc;
  assign query_acc = start && !busy && (in_action == smm_pkg::ACT_QUERY);

  // The mask word is always the wide form of the found bit.
  a_mask_matches_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_mask_word == {32{out_found}}))
    else $error("mask word does not agree with found");

  // A result comes only from a query accepted last cycle or one still in flight.
  a_result_has_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) || $past(query_acc)))
    else $error("result without a pending query transaction");

  // Only a query transaction makes the block busy.
  a_busy_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(query_acc))
    else $error("busy rose without an accepted query");

  // A sweep always ends with its result.
  a_busy_ends_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> out_valid)
    else $error("busy fell without a result");

endmodule

bind set_membership_mask smm_checker u_smm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_action     (in_action),
  .out_valid     (out_valid),
  .out_mask_word (out_mask_word),
  .out_found     (out_found)
);

`default_nettype wire

FILE: tb/sv/set_membership_mask_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for set_membership_mask: directed and random load, query and
// clear transactions, with a scoreboard that tracks the test set. Depends on smm_pkg.

module set_membership_mask_tb;

  localparam int          SET_DEPTH      = 1024;
  localparam logic [1:0]  ACT_UNUSED     = 2'd3;
  localparam int          QUIET_CYCLES   = 20;
  localparam int          DRAIN_CYCLES   = 150;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          MAX_GAP        = 40;

  typedef struct packed {
    logic [31:0] mask_word;
    logic        found;
    logic        set_overflowed;
    logic        end_of_tensor;
  } mask_result_t;

  // Tracks the test set and the expected answer of every accepted query.
  class membership_scoreboard;
    logic [31:0]  test_values[$];
    mask_result_t expected_masks[$];
    bit           overflow;
    bit           invert;
    int           depth;
    int           faults;

    function new(int set_depth);
      depth    = set_depth;
      overflow = 0;
      invert   = 0;
      faults   = 0;
    endfunction

    function bit value_in_set(logic [31:0] val);
      foreach (test_values[i])
        if (test_values[i] == val) return 1'b1;
      return 1'b0;
    endfunction

    function int pending();
      return expected_masks.size();
    endfunction

    function void report_fault(string msg);
      faults++;
      if (faults <= 10) $display("[%0t] %s", $realtime, msg);
    endfunction

    function void note_item(logic [1:0] act, logic [31:0] val, logic last);
      mask_result_t res;
      bit member;
      case (act)
        smm_pkg::ACT_LOAD: begin
          if (test_values.size() < depth) test_values.push_back(val);
          else overflow = 1'b1;
        end
        smm_pkg::ACT_CLEAR: begin
          test_values.delete();
          overflow = 1'b0;
        end
        smm_pkg::ACT_QUERY: begin
          member             = value_in_set(val) ^ invert;
          res.mask_word      = member ? smm_pkg::MASK_ALL : smm_pkg::MASK_NONE;
          res.found          = member;
          res.set_overflowed = overflow;
          res.end_of_tensor  = last;
          expected_masks.push_back(res);
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [31:0] mask, logic found, logic ovf, logic eot);
      mask_result_t want;
      if (expected_masks.size() == 0) begin
        report_fault($sformatf("result with nothing expected: mask %h found %b ovf %b eot %b",
                               mask, found, ovf, eot));
        return;
      end
      want = expected_masks.pop_front();
      if (want.mask_word !== mask || want.found !== found ||
          want.set_overflowed !== ovf || want.end_of_tensor !== eot)
        report_fault($sformatf({"mismatch: expected mask %h found %b ovf %b eot %b, ",
                                "got mask %h found %b ovf %b eot %b"},
                               want.mask_word, want.found, want.set_overflowed,
                               want.end_of_tensor, mask, found, ovf, eot));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_action;
  logic [31:0] in_value;
  logic        in_last_element;
  logic        out_valid;
  logic [31:0] out_mask_word;
  logic        out_found;
  logic        out_set_overflowed;
  logic        out_end_of_tensor;
  logic        cfg_we;
  logic        cfg_wdata;

  membership_scoreboard set_check;
  int idle_pct;
  int stall_cycles;

  set_membership_mask #(
    .DATA_WIDTH(32),
    .SET_DEPTH (SET_DEPTH)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_action         (in_action),
    .in_value          (in_value),
    .in_last_element   (in_last_element),
    .out_valid         (out_valid),
    .out_mask_word     (out_mask_word),
    .out_found         (out_found),
    .out_set_overflowed(out_set_overflowed),
    .out_end_of_tensor (out_end_of_tensor),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Outputs are sampled mid-cycle, away from the edges where they change.
  always @(negedge clk) begin
    if (rst_n && out_valid)
      set_check.check_result(out_mask_word, out_found, out_set_overflowed, out_end_of_tensor);
  end

  always @(negedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] act, input logic [31:0] val, input logic last);
    int gap;
    bit taken;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_action       <= act;
    in_value        <= val;
    in_last_element <= last;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end
    set_check.note_item(act, val, last);
  endtask

  // Registers change only with no query in flight and the block quiet.
  task automatic write_invert(input logic val);
    start <= 1'b0;
    while (set_check.pending() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    set_check.invert = val;
  endtask

  function automatic logic [31:0] fresh_value();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return 32'h0000_0000;
    if (sel == 1) return 32'hFFFF_FFFF;
    if (sel == 2) return 32'(1) << $urandom_range(31);
    if (sel == 3) return $urandom_range(15);
    if (sel == 4 && set_check.test_values.size() > 0)
      return set_check.test_values[$urandom_range(set_check.test_values.size() - 1)];
    return $urandom;
  endfunction

  // Queries lean toward members and near misses one bit away from a member.
  function automatic logic [31:0] query_value();
    int sel;
    logic [31:0] member;
    sel = $urandom_range(9);
    if (set_check.test_values.size() == 0 || sel >= 7) return fresh_value();
    member = set_check.test_values[$urandom_range(set_check.test_values.size() - 1)];
    if (sel >= 5) return member ^ (32'(1) << $urandom_range(31));
    return member;
  endfunction

  task automatic run_random(input int pct, input int n_items);
    int done_items;
    int pick;
    int k;
    int q;
    int i;
    logic last;
    done_items = 0;
    idle_pct   = pct;
    while (done_items < n_items) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_item(smm_pkg::ACT_CLEAR, $urandom, $urandom_range(1));
        k = ($urandom_range(19) == 0) ? $urandom_range(25, 120) : $urandom_range(0, 24);
        repeat (k) send_item(smm_pkg::ACT_LOAD, fresh_value(), $urandom_range(1));
        q = $urandom_range(1, 12);
        for (i = 0; i < q; i++) begin
          last = (i == q - 1) ? 1'b1 : ($urandom_range(4) == 0);
          send_item(smm_pkg::ACT_QUERY, query_value(), last);
        end
        done_items += 1 + k + q;
      end else if (pick < 85) begin
        send_item($urandom_range(1) ? smm_pkg::ACT_QUERY : smm_pkg::ACT_LOAD, query_value(),
                  $urandom_range(1));
        done_items++;
      end else if (pick < 95) begin
        send_item(ACT_UNUSED, $urandom, $urandom_range(1));
      end else begin
        send_item(smm_pkg::ACT_CLEAR, $urandom, $urandom_range(1));
        done_items++;
      end
    end
  endtask

  initial begin
    logic [31:0] first_entry;
    logic [31:0] final_entry;
    set_check       = new(SET_DEPTH);
    idle_pct        = 0;
    stall_cycles    = 0;
    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_action       <= smm_pkg::ACT_LOAD;
    in_value        <= '0;
    in_last_element <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_invert(1'b0);
    send_item(smm_pkg::ACT_QUERY, 32'h0000_0000, 1'b1);
    send_item(ACT_UNUSED, 32'hFFFF_FFFF, 1'b1);
    send_item(smm_pkg::ACT_LOAD, 32'h0000_0000, 1'b0);
    send_item(smm_pkg::ACT_LOAD, 32'hFFFF_FFFF, 1'b1);
    send_item(smm_pkg::ACT_LOAD, 32'h8000_0000, 1'b0);
    send_item(smm_pkg::ACT_LOAD, 32'h0000_0001, 1'b0);
    send_item(smm_pkg::ACT_QUERY, 32'h0000_0000, 1'b0);
    send_item(smm_pkg::ACT_QUERY, 32'hFFFF_FFFF, 1'b1);
    send_item(smm_pkg::ACT_QUERY, 32'h7FFF_FFFF, 1'b0);
    send_item(smm_pkg::ACT_QUERY, 32'h8000_0000, 1'b0);
    send_item(smm_pkg::ACT_QUERY, 32'h0000_0002, 1'b1);
    send_item(smm_pkg::ACT_CLEAR, 32'h0000_0000, 1'b0);
    send_item(smm_pkg::ACT_QUERY, 32'h0000_0000, 1'b1);

    write_invert(1'b1);
    send_item(smm_pkg::ACT_QUERY, 32'h0000_0000, 1'b0);
    send_item(smm_pkg::ACT_LOAD, 32'hA5A5_A5A5, 1'b0);
    send_item(smm_pkg::ACT_QUERY, 32'hA5A5_A5A5, 1'b0);
    send_item(smm_pkg::ACT_QUERY, 32'h5A5A_5A5A, 1'b1);

    // Fill the set to capacity, then push two loads that must be dropped.
    send_item(smm_pkg::ACT_CLEAR, 32'h0000_0000, 1'b0);
    first_entry = $urandom;
    send_item(smm_pkg::ACT_LOAD, first_entry, 1'b0);
    repeat (SET_DEPTH - 2) send_item(smm_pkg::ACT_LOAD, $urandom, $urandom_range(1));
    final_entry = $urandom;
    send_item(smm_pkg::ACT_LOAD, final_entry, 1'b1);
    send_item(smm_pkg::ACT_LOAD, $urandom, 1'b0);
    send_item(smm_pkg::ACT_LOAD, $urandom, 1'b1);
    send_item(smm_pkg::ACT_QUERY, final_entry, 1'b0);
    send_item(smm_pkg::ACT_QUERY, first_entry, 1'b1);
    send_item(smm_pkg::ACT_QUERY, $urandom, 1'b0);

    write_invert(1'b0);
    send_item(smm_pkg::ACT_QUERY, final_entry, 1'b1);
    send_item(smm_pkg::ACT_QUERY, first_entry ^ 32'h0000_0100, 1'b0);
    send_item(smm_pkg::ACT_CLEAR, 32'hFFFF_FFFF, 1'b1);
    send_item(smm_pkg::ACT_QUERY, first_entry, 1'b1);

    run_random(16, 135);
    write_invert(1'b1);
    run_random(50, 135);
    write_invert(1'b0);
    run_random(0, 135);

    start <= 1'b0;
    while (set_check.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (set_check.faults == 0 && set_check.pending() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
